>>> hw/rtl/peer_health_tracker_core_assert.svh
// Assertion macros for the peer health tracker checker.
`ifndef PEER_HEALTH_TRACKER_CORE_ASSERT_SVH
`define PEER_HEALTH_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define PHT_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("peer health tracker: implication failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define PHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("peer health tracker: next-cycle implication failed");

`endif

>>> hw/rtl/pht_pkg.sv
// Types, constants and helpers for the peer health tracker.
package pht_pkg;

	localparam int PEER_COUNT = 64;
	localparam int PEER_AW    = (PEER_COUNT > 1) ? $clog2(PEER_COUNT) : 1;

	// Health state codes
	localparam logic [1:0] HS_UP       = 2'd0;
	localparam logic [1:0] HS_DOWN     = 2'd1;
	localparam logic [1:0] HS_CHECKING = 2'd2;

	// Configuration register indexes
	localparam logic REG_MANDATORY = 1'b0;
	localparam logic REG_RELOAD    = 1'b1;

	typedef struct packed {
		logic [5:0]  peer;
		logic        passed;
		logic [15:0] pass_threshold;
		logic [15:0] fail_threshold;
		logic        admin_down;
		logic [47:0] now_ms;
		logic [37:0] now_sec;
	} item_t;

	typedef struct packed {
		logic [31:0] checks;
		logic [31:0] fails;
		logic [31:0] pass_run;
		logic [31:0] fail_run;
		logic [31:0] unhealthy;
		logic [1:0]  state;
		logic        down_open;
		logic [47:0] down_start;
		logic [47:0] downtime;
		logic [37:0] up_since;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	typedef struct packed {
		logic went_down;
		logic came_up;
	} flags_t;

	function automatic logic [31:0] sat_inc(input logic [31:0] v);
		return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
	endfunction

endpackage

>>> hw/rtl/pht_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module pht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hw/rtl/pht_update.sv
// Next-record logic for one health-check request against one peer record.
module pht_update
	import pht_pkg::*;
(
	input  item_t  item,
	input  rec_t   cur,
	input  logic   mandatory_mode,
	input  logic   reload_in_progress,
	output rec_t   nxt,
	output flags_t flags
);

	logic [47:0] elapsed;
	logic [48:0] sum;
	logic [47:0] sum_sat;
	logic [31:0] checks_inc;
	logic        first_rule;

	// elapsed wraps modulo 2^48
	assign elapsed    = item.now_ms - cur.down_start;
	assign sum        = {1'b0, cur.downtime} + {1'b0, elapsed};
	assign sum_sat    = sum[48] ? 48'hFFFF_FFFF_FFFF : sum[47:0];
	assign checks_inc = sat_inc(cur.checks);
	assign first_rule = mandatory_mode && !reload_in_progress &&
		(checks_inc == 32'd1) && !item.admin_down;

	always_comb begin
		nxt             = cur;
		flags           = '0;
		nxt.checks      = checks_inc;
		if (item.passed) begin
			nxt.fail_run = '0;
			nxt.pass_run = sat_inc(cur.pass_run);
			if (nxt.pass_run >= {16'd0, item.pass_threshold}) begin
				nxt.state = HS_UP;
				if (cur.down_open) begin
					nxt.downtime  = sum_sat;
					nxt.up_since  = item.now_sec;
					flags.came_up = 1'b1;
				end
				nxt.down_open  = 1'b0;
				nxt.down_start = '0;
			end
			if (first_rule) begin
				nxt.state = HS_UP;
			end
		end else begin
			nxt.fails    = sat_inc(cur.fails);
			nxt.pass_run = '0;
			nxt.fail_run = sat_inc(cur.fail_run);
			if (nxt.fail_run == {16'd0, item.fail_threshold}) begin
				nxt.unhealthy = sat_inc(cur.unhealthy);
			end
			if ((nxt.fail_run == {16'd0, item.fail_threshold}) || first_rule) begin
				nxt.state       = HS_DOWN;
				nxt.down_open   = 1'b1;
				nxt.down_start  = item.now_ms;
				flags.went_down = 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/peer_health_tracker_core.sv
// Top level of the peer health tracker: per-peer health-check bookkeeping.
// A request taken at a clock edge goes through the stage 1 request register and
// then the stage 2 result registers, which raise done with the result.
// Throughput: one request per cycle, busy is never raised and done cannot stall.
// The peer record memory has one read and one write port; a request right after
// one to the same peer takes the just-written record from a bypass register.
// Reset clears the record and state valid bits at once; no clearing pass is needed.
module peer_health_tracker_core
	import pht_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic        cfg_wdata,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [5:0]  peer_index,
	input  logic        check_passed,
	input  logic [15:0] pass_threshold,
	input  logic [15:0] fail_threshold,
	input  logic        admin_down,
	input  logic [47:0] now_ms,
	input  logic [37:0] now_sec,
	// result
	output logic        done,
	output logic [5:0]  result_peer,
	output logic [1:0]  health_state,
	output logic [31:0] total_checks,
	output logic [31:0] total_fails,
	output logic [31:0] pass_run,
	output logic [31:0] fail_run,
	output logic [31:0] unhealthy_events,
	output logic [47:0] downtime_total_ms,
	output logic [37:0] up_since_sec,
	output logic        went_down,
	output logic        came_up
);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic mandatory_q;
	logic reload_q;

	// ---------------------------------------------------------------
	// Per-peer valid bits. rec_vld_q marks a record that has been written
	// since reset; an unwritten record reads as all zero. st_vld_q marks a
	// state field written since the last mode write; otherwise the state is
	// the one the mode implies (checking in mandatory mode, else up).
	// ---------------------------------------------------------------
	logic [PEER_COUNT-1:0] rec_vld_q;
	logic [PEER_COUNT-1:0] st_vld_q;

	// ---------------------------------------------------------------
	// Stage 1: request register, alongside the memory read
	// ---------------------------------------------------------------
	logic               accept;
	logic               in_range;
	logic [PEER_AW-1:0] rd_addr;
	logic               vld_s1;
	item_t              item_s1;
	logic               inrng_s1;
	logic [PEER_AW-1:0] addr_s1;
	logic               recv_s1;
	logic               stv_s1;
	logic               fwd_s1;

	// Write-back and bypass
	logic               wr_en;
	rec_t               byp_q;
	logic [REC_W-1:0]   ram_rdata;
	rec_t               ram_rec;
	rec_t               cur;
	rec_t               nxt;
	flags_t             flags;

	// Stage 2: result registers
	logic        done_q;
	logic [5:0]  peer_q;
	logic [1:0]  state_q;
	logic [31:0] checks_q;
	logic [31:0] fails_q;
	logic [31:0] prun_q;
	logic [31:0] frun_q;
	logic [31:0] unh_q;
	logic [47:0] downtime_q;
	logic [37:0] up_since_q;
	logic        went_down_q;
	logic        came_up_q;

	// The block never holds off a request.
	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign in_range = 32'(peer_index) < 32'(PEER_COUNT);
	assign rd_addr  = PEER_AW'(peer_index);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mandatory_q <= 1'b0;
			reload_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MANDATORY: mandatory_q <= cfg_wdata;
				REG_RELOAD:    reload_q    <= cfg_wdata;
				default:       ;
			endcase
		end
	end

	// Stage 1 control. A request that hits the peer being written back at
	// this same edge would read stale memory; it takes the bypass instead.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			fwd_s1 <= accept && wr_en && (addr_s1 == rd_addr);
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.peer           <= peer_index;
			item_s1.passed         <= check_passed;
			item_s1.pass_threshold <= pass_threshold;
			item_s1.fail_threshold <= fail_threshold;
			item_s1.admin_down     <= admin_down;
			item_s1.now_ms         <= now_ms;
			item_s1.now_sec        <= now_sec;
			inrng_s1               <= in_range;
			addr_s1                <= rd_addr;
			recv_s1                <= in_range && rec_vld_q[rd_addr];
			stv_s1                 <= in_range && st_vld_q[rd_addr];
		end
	end

	pht_ram #(
		.WIDTH (REC_W),
		.DEPTH (PEER_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (addr_s1),
		.wdata (nxt),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign ram_rec = rec_t'(ram_rdata);

	// Current record: bypass, memory, or the reset value; the state field
	// falls back to the mode default when not written since the mode changed.
	always_comb begin
		if (fwd_s1) begin
			cur = byp_q;
		end else if (recv_s1) begin
			cur = ram_rec;
		end else begin
			cur = '0;
		end
		if (!fwd_s1 && !stv_s1) begin
			cur.state = mandatory_q ? HS_CHECKING : HS_UP;
		end
	end

	pht_update u_update (
		.item               (item_s1),
		.cur                (cur),
		.mandatory_mode     (mandatory_q),
		.reload_in_progress (reload_q),
		.nxt                (nxt),
		.flags              (flags)
	);

	// Out-of-range peers leave every record untouched.
	assign wr_en = vld_s1 && inrng_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			byp_q <= nxt;
		end
	end

	// Valid bits: a mode write sends every state back to the mode default.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_vld_q <= '0;
			st_vld_q  <= '0;
		end else begin
			if (cfg_we && (cfg_addr == REG_MANDATORY)) begin
				st_vld_q <= '0;
			end
			if (wr_en) begin
				rec_vld_q[addr_s1] <= 1'b1;
				st_vld_q[addr_s1]  <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: result registers. Strobe and event flags are reset; the
	// payload is only loaded alongside the strobe.
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q      <= 1'b0;
			went_down_q <= 1'b0;
			came_up_q   <= 1'b0;
		end else begin
			done_q      <= vld_s1;
			went_down_q <= wr_en && flags.went_down;
			came_up_q   <= wr_en && flags.came_up;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			peer_q <= item_s1.peer;
			if (inrng_s1) begin
				state_q    <= nxt.state;
				checks_q   <= nxt.checks;
				fails_q    <= nxt.fails;
				prun_q     <= nxt.pass_run;
				frun_q     <= nxt.fail_run;
				unh_q      <= nxt.unhealthy;
				downtime_q <= nxt.downtime;
				up_since_q <= nxt.up_since;
			end else begin
				state_q    <= '0;
				checks_q   <= '0;
				fails_q    <= '0;
				prun_q     <= '0;
				frun_q     <= '0;
				unh_q      <= '0;
				downtime_q <= '0;
				up_since_q <= '0;
			end
		end
	end

	assign done              = done_q;
	assign result_peer       = peer_q;
	assign health_state      = state_q;
	assign total_checks      = checks_q;
	assign total_fails       = fails_q;
	assign pass_run          = prun_q;
	assign fail_run          = frun_q;
	assign unhealthy_events  = unh_q;
	assign downtime_total_ms = downtime_q;
	assign up_since_sec      = up_since_q;
	assign went_down         = went_down_q;
	assign came_up           = came_up_q;

endmodule

>>> hw/rtl/pht_checker.sv
// Port-level checker for the peer health tracker, bound to the top level.
`include "peer_health_tracker_core_assert.svh"

module pht_checker
	import pht_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] health_state,
	input logic       went_down,
	input logic       came_up
);

	`PHT_ASSERT_IMPLY(a_done_from_req, done, $past(start && !busy, 2))
	`PHT_ASSERT_NEXT(a_req_gives_done, start && !busy, ##1 done)
	`PHT_ASSERT_IMPLY(a_down_state, done && went_down, health_state == HS_DOWN)
	`PHT_ASSERT_IMPLY(a_up_state, done && came_up, (health_state == HS_UP) && !went_down)
	`PHT_ASSERT_IMPLY(a_flags_need_done, !done, !went_down && !came_up)

endmodule

bind peer_health_tracker_core pht_checker u_pht_checker (.*);

>>> verif/tb_top.sv
// Self-checking testbench for the peer health tracker core.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pht_pkg::*;

	localparam logic [47:0] MS_MAX  = '1;
	localparam logic [37:0] SEC_MAX = '1;
	localparam int          N_PHASE_ITEMS = 160;

	// one tracked update, as the block reports it
	typedef struct packed {
		logic [5:0]  peer;
		logic [1:0]  state;
		logic [31:0] checks;
		logic [31:0] fails;
		logic [31:0] pass_run;
		logic [31:0] fail_run;
		logic [31:0] unhealthy;
		logic [47:0] downtime;
		logic [37:0] up_since;
		logic        went_down;
		logic        came_up;
	} peer_update_t;

	// directed script row: a register write or a health-check request,
	// with hand-typed expectations on the rows marked pinned
	typedef enum logic {ROW_CHECK, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e   kind;
		logic        reg_idx;
		logic        reg_val;
		item_t       it;
		logic        pinned;
		logic [1:0]  state;
		logic [31:0] checks;
		logic [31:0] fails;
		logic        went_down;
		logic        came_up;
		logic [47:0] downtime;
	} script_row_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_addr;
	logic        cfg_wdata;
	logic        start;
	logic        busy;
	logic [5:0]  peer_index;
	logic        check_passed;
	logic [15:0] pass_threshold;
	logic [15:0] fail_threshold;
	logic        admin_down;
	logic [47:0] now_ms;
	logic [37:0] now_sec;
	logic        done;
	logic [5:0]  result_peer;
	logic [1:0]  health_state;
	logic [31:0] total_checks;
	logic [31:0] total_fails;
	logic [31:0] pass_run;
	logic [31:0] fail_run;
	logic [31:0] unhealthy_events;
	logic [47:0] downtime_total_ms;
	logic [37:0] up_since_sec;
	logic        went_down;
	logic        came_up;

	peer_health_tracker_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_addr         (cfg_addr),
		.cfg_wdata        (cfg_wdata),
		.start            (start),
		.busy             (busy),
		.peer_index       (peer_index),
		.check_passed     (check_passed),
		.pass_threshold   (pass_threshold),
		.fail_threshold   (fail_threshold),
		.admin_down       (admin_down),
		.now_ms           (now_ms),
		.now_sec          (now_sec),
		.done             (done),
		.result_peer      (result_peer),
		.health_state     (health_state),
		.total_checks     (total_checks),
		.total_fails      (total_fails),
		.pass_run         (pass_run),
		.fail_run         (fail_run),
		.unhealthy_events (unhealthy_events),
		.downtime_total_ms(downtime_total_ms),
		.up_since_sec     (up_since_sec),
		.went_down        (went_down),
		.came_up          (came_up)
	);

	// ------------------------------------------------------------------
	// Shadow copy of the peer table and the two mode bits
	// ------------------------------------------------------------------
	logic [31:0] sh_checks    [PEER_COUNT];
	logic [31:0] sh_fails     [PEER_COUNT];
	logic [31:0] sh_pass_run  [PEER_COUNT];
	logic [31:0] sh_fail_run  [PEER_COUNT];
	logic [31:0] sh_unhealthy [PEER_COUNT];
	logic [1:0]  sh_state     [PEER_COUNT];
	logic        sh_down_open [PEER_COUNT];
	logic [47:0] sh_down_at   [PEER_COUNT];
	logic [47:0] sh_downtime  [PEER_COUNT];
	logic [37:0] sh_up_since  [PEER_COUNT];
	logic        mandatory_on;
	logic        reload_on;

	// updates still owed by the block, oldest first
	peer_update_t pending_updates [$];

	int n_errors;
	int n_requests;
	int n_results;
	int n_marked_down;
	int n_came_up;

	// random stimulus shaping
	logic [5:0]  cur_peer;
	logic        cur_passed;
	logic [47:0] ms_clock;
	logic [15:0] pass_th_of [PEER_COUNT];
	logic [15:0] fail_th_of [PEER_COUNT];

	// ------------------------------------------------------------------
	// Directed script. Pinned rows carry values read straight off the
	// rules; the rest rely on the shadow model alone.
	// ------------------------------------------------------------------
	script_row_t script [27] = '{
		// first pass at threshold 1: up, nothing to close
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd0, 1'b1, 16'd1, 16'd1, 1'b0, 48'd0, 38'd0},
			1'b1, HS_UP, 32'd1, 32'd0, 1'b0, 1'b0, 48'd0},
		// down period opening at time zero
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd0, 1'b0, 16'd1, 16'd1, 1'b0, 48'd0, 38'd0},
			1'b1, HS_DOWN, 32'd2, 32'd1, 1'b1, 1'b0, 48'd0},
		// ... must still be closed and counted
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd0, 1'b1, 16'd1, 16'd1, 1'b0, 48'd1000, 38'd1},
			1'b1, HS_UP, 32'd3, 32'd1, 1'b0, 1'b1, 48'd1000},
		// zero fail threshold never fires
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd1, 1'b0, 16'd1, 16'd0, 1'b0, 48'd10, 38'd0},
			1'b1, HS_UP, 32'd1, 32'd1, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd1, 1'b0, 16'd1, 16'd0, 1'b0, 48'd11, 38'd0},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		// zero pass threshold: any pass marks up
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd1, 1'b1, 16'd0, 16'd0, 1'b0, 48'd12, 38'd0},
			1'b1, HS_UP, 32'd3, 32'd2, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b0, 16'd2, 16'd2, 1'b0, 48'd1, 38'd0},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b0, 16'd2, 16'd2, 1'b0, 48'd1, 38'd0},
			1'b1, HS_DOWN, 32'd2, 32'd2, 1'b1, 1'b0, 48'd0},
		// run past the threshold: no second event
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b0, 16'd2, 16'd2, 1'b0, 48'd2, 38'd0},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b1, 16'd2, 16'd2, 1'b0, 48'd0, 38'd0},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		// clock went backwards: elapsed wraps to all ones
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b1, 16'd2, 16'd2, 1'b0, 48'd0, SEC_MAX},
			1'b1, HS_UP, 32'd5, 32'd3, 1'b0, 1'b1, MS_MAX},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b0, 16'd2, 16'd1, 1'b0, MS_MAX, 38'd0},
			1'b1, HS_DOWN, 32'd6, 32'd4, 1'b1, 1'b0, MS_MAX},
		// downtime sum saturates
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd2, 1'b1, 16'd1, 16'd1, 1'b0, 48'd5, 38'd2},
			1'b1, HS_UP, 32'd7, 32'd4, 1'b0, 1'b1, MS_MAX},
		// field extremes on the top peer
		'{ROW_CHECK, 1'b0, 1'b0,
			'{6'd63, 1'b1, 16'hFFFF, 16'hFFFF, 1'b1, MS_MAX, SEC_MAX},
			1'b1, HS_UP, 32'd1, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0,
			'{6'd63, 1'b0, 16'hFFFF, 16'hFFFF, 1'b1, MS_MAX, SEC_MAX},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		// mandatory mode: every peer to checking
		'{ROW_WRITE, REG_MANDATORY, 1'b1, '0, 1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		// first check decides at once
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd3, 1'b1, 16'd5, 16'd5, 1'b0, 48'd100, 38'd0},
			1'b1, HS_UP, 32'd1, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd4, 1'b0, 16'd5, 16'd5, 1'b0, 48'd200, 38'd0},
			1'b1, HS_DOWN, 32'd1, 32'd1, 1'b1, 1'b0, 48'd0},
		// admin down blocks the first-check rule
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd5, 1'b1, 16'd5, 16'd5, 1'b1, 48'd300, 38'd0},
			1'b1, HS_CHECKING, 32'd1, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd4, 1'b1, 16'd1, 16'd5, 1'b0, 48'd700, 38'd3},
			1'b1, HS_UP, 32'd2, 32'd1, 1'b0, 1'b1, 48'd500},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd0, 1'b0, 16'd5, 16'd5, 1'b0, 48'd800, 38'd3},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		// reload suppresses the first-check rule
		'{ROW_WRITE, REG_RELOAD, 1'b1, '0, 1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd6, 1'b0, 16'd3, 16'd3, 1'b0, 48'd900, 38'd3},
			1'b1, HS_CHECKING, 32'd1, 32'd1, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd6, 1'b1, 16'd1, 16'd3, 1'b0, 48'd950, 38'd3},
			1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_WRITE, REG_RELOAD, 1'b0, '0, 1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_WRITE, REG_MANDATORY, 1'b0, '0, 1'b0, HS_UP, 32'd0, 32'd0, 1'b0, 1'b0, 48'd0},
		'{ROW_CHECK, 1'b0, 1'b0, '{6'd7, 1'b1, 16'd3, 16'd3, 1'b0, 48'd1000, 38'd4},
			1'b1, HS_UP, 32'd1, 32'd0, 1'b0, 1'b0, 48'd0}
	};

	// ------------------------------------------------------------------
	// Clock and watchdog
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// the timeout allows many times the worst honest run
	initial begin
		#2_000_000;
		$display("tb_top: timed out with %0d updates outstanding", pending_updates.size());
		$display("tb_top: done, errors");
		$finish;
	end

	// ------------------------------------------------------------------
	// Shadow model
	// ------------------------------------------------------------------
	function automatic logic [31:0] count_up(input logic [31:0] v);
		return (v == '1) ? v : v + 32'd1;
	endfunction

	// Apply one health check to the shadow table and return the update the
	// block ought to report for it.
	task automatic apply_check(input item_t it, output peer_update_t upd);
		int          p;
		logic        first_check;
		logic [47:0] elapsed;
		logic [48:0] sum;
		upd      = '0;
		upd.peer = it.peer;
		p        = int'(it.peer);
		if (p >= PEER_COUNT)
			return;

		sh_checks[p] = count_up(sh_checks[p]);
		// mandatory first-check rule: only while the count sits at exactly one
		first_check = mandatory_on && !reload_on && sh_checks[p] == 32'd1 &&
			!it.admin_down;

		if (it.passed) begin
			sh_fail_run[p] = '0;
			sh_pass_run[p] = count_up(sh_pass_run[p]);
			if (sh_pass_run[p] >= {16'd0, it.pass_threshold}) begin
				sh_state[p] = HS_UP;
				if (sh_down_open[p]) begin
					// elapsed wraps modulo 2^48, the running sum clamps
					elapsed        = it.now_ms - sh_down_at[p];
					sum            = {1'b0, sh_downtime[p]} + {1'b0, elapsed};
					sh_downtime[p] = sum[48] ? MS_MAX : sum[47:0];
					sh_up_since[p] = it.now_sec;
					upd.came_up    = 1'b1;
				end
				sh_down_open[p] = 1'b0;
				sh_down_at[p]   = '0;
			end
			if (first_check)
				sh_state[p] = HS_UP;
		end else begin
			sh_fails[p]    = count_up(sh_fails[p]);
			sh_pass_run[p] = '0;
			sh_fail_run[p] = count_up(sh_fail_run[p]);
			// equality, not >=: a zero threshold never fires
			if (sh_fail_run[p] == {16'd0, it.fail_threshold}) begin
				sh_unhealthy[p] = count_up(sh_unhealthy[p]);
				sh_state[p]     = HS_DOWN;
				sh_down_open[p] = 1'b1;
				sh_down_at[p]   = it.now_ms;
				upd.went_down   = 1'b1;
			end
			if (first_check) begin
				sh_state[p]     = HS_DOWN;
				sh_down_open[p] = 1'b1;
				sh_down_at[p]   = it.now_ms;
				upd.went_down   = 1'b1;
			end
		end

		upd.state     = sh_state[p];
		upd.checks    = sh_checks[p];
		upd.fails     = sh_fails[p];
		upd.pass_run  = sh_pass_run[p];
		upd.fail_run  = sh_fail_run[p];
		upd.unhealthy = sh_unhealthy[p];
		upd.downtime  = sh_downtime[p];
		upd.up_since  = sh_up_since[p];
	endtask

	// ------------------------------------------------------------------
	// Driving side: everything changes on the falling edge
	// ------------------------------------------------------------------

	// Present one request and hold it until taken; the expected update is
	// queued at the edge that takes it.
	task automatic send_check(input item_t it);
		peer_update_t upd;
		@(negedge clk);
		start          <= 1'b1;
		peer_index     <= it.peer;
		check_passed   <= it.passed;
		pass_threshold <= it.pass_threshold;
		fail_threshold <= it.fail_threshold;
		admin_down     <= it.admin_down;
		now_ms         <= it.now_ms;
		now_sec        <= it.now_sec;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		apply_check(it, upd);
		pending_updates.push_back(upd);
		n_requests++;
	endtask

	task automatic idle_for(input int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	// stop sending and let every owed update come back
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		wait (pending_updates.size() == 0);
	endtask

	// Register writes only with the block idle; a short settle after the
	// last update lets the pipeline empty.
	task automatic write_reg(input logic idx, input logic val);
		drain();
		repeat (4) @(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= val;
		if (idx == REG_MANDATORY) begin
			mandatory_on = val;
			for (int i = 0; i < PEER_COUNT; i++)
				sh_state[i] = val ? HS_CHECKING : HS_UP;
		end else begin
			reload_on = val;
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly runs of passes or fails on a handful of peers with steady
	// thresholds and a forward-moving clock; now and then a stray peer,
	// a random threshold or a time jump.
	task automatic make_random_check(output item_t it);
		if ($urandom_range(0, 9) < 3)
			cur_peer = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(0, 63))
				: 6'($urandom_range(0, 7));
		if ($urandom_range(0, 3) == 0)
			cur_passed = ~cur_passed;
		ms_clock          = ms_clock + 48'($urandom_range(0, 4000));
		it.peer           = cur_peer;
		it.passed         = cur_passed;
		it.pass_threshold = pass_th_of[cur_peer];
		it.fail_threshold = fail_th_of[cur_peer];
		it.admin_down     = ($urandom_range(0, 9) == 0);
		it.now_ms         = ms_clock;
		it.now_sec        = 38'(ms_clock / 48'd1000);
		if ($urandom_range(0, 19) == 0)
			it.pass_threshold = 16'($urandom);
		if ($urandom_range(0, 19) == 0)
			it.fail_threshold = 16'($urandom);
		if ($urandom_range(0, 29) == 0)
			it.now_ms = {16'($urandom), 32'($urandom)};
		if ($urandom_range(0, 29) == 0)
			it.now_sec = {6'($urandom), 32'($urandom)};
	endtask

	// ------------------------------------------------------------------
	// Result side: sampled on the rising edge, the strobe lasts one cycle
	// ------------------------------------------------------------------
	task automatic note_error(input string what, input logic [63:0] want,
			input logic [63:0] got);
		n_errors++;
		if (n_errors <= 10)
			$display("tb_top: %0t %s: expected %0h, got %0h", $realtime, what, want, got);
	endtask

	task automatic check_field(input string what, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want)
			note_error(what, want, got);
	endtask

	always @(posedge clk) begin
		peer_update_t want;
		if (arst_n && done === 1'b1) begin
			if (pending_updates.size() == 0) begin
				note_error("update with none owed", 64'd0, {58'd0, result_peer});
			end else begin
				want = pending_updates.pop_front();
				n_results++;
				check_field("result_peer", 64'(want.peer), 64'(result_peer));
				check_field("health_state", 64'(want.state), 64'(health_state));
				check_field("total_checks", 64'(want.checks), 64'(total_checks));
				check_field("total_fails", 64'(want.fails), 64'(total_fails));
				check_field("pass_run", 64'(want.pass_run), 64'(pass_run));
				check_field("fail_run", 64'(want.fail_run), 64'(fail_run));
				check_field("unhealthy_events", 64'(want.unhealthy),
					64'(unhealthy_events));
				check_field("downtime_total_ms", 64'(want.downtime),
					64'(downtime_total_ms));
				check_field("up_since_sec", 64'(want.up_since), 64'(up_since_sec));
				check_field("went_down", 64'(want.went_down), 64'(went_down));
				check_field("came_up", 64'(want.came_up), 64'(came_up));
				if (want.went_down)
					n_marked_down++;
				if (want.came_up)
					n_came_up++;
			end
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		peer_update_t pin_upd;
		item_t        it;
		logic [1:0]   phase_modes [5];
		int           sent;
		int           burst;

		phase_modes    = '{2'b10, 2'b00, 2'b11, 2'b01, 2'b10};
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_addr       = REG_MANDATORY;
		cfg_wdata      = 1'b0;
		start          = 1'b0;
		peer_index     = '0;
		check_passed   = 1'b0;
		pass_threshold = '0;
		fail_threshold = '0;
		admin_down     = 1'b0;
		now_ms         = '0;
		now_sec        = '0;
		n_errors       = 0;
		n_requests     = 0;
		n_results      = 0;
		n_marked_down  = 0;
		n_came_up      = 0;
		cur_peer       = '0;
		cur_passed     = 1'b1;
		ms_clock       = 48'd5000;
		mandatory_on   = 1'b0;
		reload_on      = 1'b0;
		for (int i = 0; i < PEER_COUNT; i++) begin
			sh_checks[i]    = '0;
			sh_fails[i]     = '0;
			sh_pass_run[i]  = '0;
			sh_fail_run[i]  = '0;
			sh_unhealthy[i] = '0;
			sh_state[i]     = HS_UP;
			sh_down_open[i] = 1'b0;
			sh_down_at[i]   = '0;
			sh_downtime[i]  = '0;
			sh_up_since[i]  = '0;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed script, requests back to back
		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE) begin
				write_reg(script[i].reg_idx, script[i].reg_val);
			end else begin
				send_check(script[i].it);
				if (script[i].pinned) begin
					// hand-typed values take the place of the shadow model's
					pin_upd           = pending_updates.pop_back();
					pin_upd.state     = script[i].state;
					pin_upd.checks    = script[i].checks;
					pin_upd.fails     = script[i].fails;
					pin_upd.went_down = script[i].went_down;
					pin_upd.came_up   = script[i].came_up;
					pin_upd.downtime  = script[i].downtime;
					pending_updates.push_back(pin_upd);
				end
			end
		end

		// random phases across every mode combination, bursts with gaps
		foreach (phase_modes[ph]) begin
			write_reg(REG_MANDATORY, phase_modes[ph][1]);
			write_reg(REG_RELOAD, phase_modes[ph][0]);
			for (int i = 0; i < PEER_COUNT; i++) begin
				pass_th_of[i] = 16'($urandom_range(0, 4));
				fail_th_of[i] = ($urandom_range(0, 9) == 0) ? 16'd0
					: 16'($urandom_range(1, 4));
			end
			sent = 0;
			while (sent < N_PHASE_ITEMS) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && sent < N_PHASE_ITEMS; b++) begin
					make_random_check(it);
					send_check(it);
					sent++;
					// mid-phase hold-off until the pipeline is empty
					if (ph == 1 && sent == N_PHASE_ITEMS / 2)
						drain();
				end
				if ($urandom_range(0, 2) != 0)
					idle_for($urandom_range(1, 6));
			end
		end

		// wind down: bounded wait for owed updates, then a short settle
		@(negedge clk);
		start <= 1'b0;
		for (int k = 0; k < 1000 && pending_updates.size() != 0; k++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_updates.size() != 0) begin
			$display("tb_top: %0d updates never reported", pending_updates.size());
			n_errors += pending_updates.size();
		end

		$display("tb_top: %0d health checks over %0d mode settings, %0d updates seen",
			n_requests, $size(phase_modes) + 1, n_results);
		$display("tb_top: %0d peers marked down, %0d down periods closed, %0d mismatches",
			n_marked_down, n_came_up, n_errors);
		if (n_errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
